/* design/skvt_pkg.sv */
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  // Table size and the widths that follow from it
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request codes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;   // compare held key with the request key
    logic rep_en;   // replace the value of the matching cell
    logic ins_en;   // shift up from the insertion point and insert
  } cell_ctl_t;

endpackage

/* design/skvt_cell.sv */
// ----------------------------------------------------------------------------
// skvt_cell
// One table slot: holds a key and value, compares against the broadcast
// request and takes its lower neighbour's entry when an insert shifts up.
// ----------------------------------------------------------------------------
module skvt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  skvt_pkg::cell_ctl_t ctl,
  input  skvt_pkg::key_t      req_key,
  input  skvt_pkg::val_t      req_val,
  input  logic                occ,
  input  logic                left_lt,
  input  skvt_pkg::key_t      left_key,
  input  skvt_pkg::val_t      left_val,
  output skvt_pkg::key_t      key_r,
  output skvt_pkg::val_t      val_r,
  output logic                lt_r,
  output logic                eq_r,
  output logic                bnd
);
  import skvt_pkg::*;

  // First slot at or above the request key
  assign bnd = !lt_r && left_lt;

  // Register the comparison flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r <= occ && (key_r < req_key);
      eq_r <= occ && (key_r == req_key);
    end
  end

  // Replace in place, or shift up and insert
  always_ff @(posedge clk) begin
    if (ctl.rep_en && eq_r) begin
      val_r <= req_val;
    end else if (ctl.ins_en && !lt_r) begin
      key_r <= left_lt ? req_key : left_key;
      val_r <= left_lt ? req_val : left_val;
    end
  end

endmodule

/* design/skvt_gather.sv */
// ----------------------------------------------------------------------------
// skvt_gather
// Collects the cell flags: encodes the one-hot boundary into a position and
// selects the value held at that slot.
// ----------------------------------------------------------------------------
module skvt_gather (
  input  logic [skvt_pkg::CAPACITY-1:0] bnd,
  input  logic [skvt_pkg::CAPACITY-1:0] eq,
  input  skvt_pkg::val_t                vals [skvt_pkg::CAPACITY],
  output skvt_pkg::idx_t                idx,
  output skvt_pkg::val_t                val,
  output logic                          hit
);
  import skvt_pkg::*;

  // Encode the boundary and mux out its value
  always_comb begin
    idx = '0;
    val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        idx = idx | IDX_W'(i);
        val = val | vals[i];
      end
    end
  end

  assign hit = |eq;

endmodule

/* design/sorted_key_value_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: func (0 set, 1 find), key_code, entry_value. An item
//   is taken on a clock edge with in_valid high and in_stall low.
//   Result channel out_*: status, value_out, position, entry_count, one
//   result per item, held in an output register until out_stall is low.
//   Each item takes two steps: a compare step, in which every cell compares
//   its key with the broadcast request, and an update step, in which the
//   boundary cell is found and the cells replace, or shift up by one and
//   insert, all in parallel. The result is loaded into the output register
//   at the end of the update step, and a new item can be taken on that same
//   edge, while the last item is still in its update step.
//   While a result waits under out_stall, one more item is taken and
//   compared; it then holds in the update step until the output register
//   frees, and in_stall stays high meanwhile.
//   Reset empties the table (entry count zero) and drops any pending result.
//   A set of an absent key with the table full answers status full.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [skvt_pkg::KEY_W-1:0]       in_key_code,
  input  logic [skvt_pkg::VAL_W-1:0]       in_entry_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [skvt_pkg::STATUS_W-1:0]    out_status,
  output logic [skvt_pkg::VAL_W-1:0]       out_value_out,
  output logic [skvt_pkg::POS_W-1:0]       out_position,
  output logic [skvt_pkg::COUNT_W-1:0]     out_entry_count
);
  import skvt_pkg::*;

  state_t    state_r, state_nxt;
  logic      func_r;
  key_t      req_key_r;
  val_t      req_val_r;
  cnt_t      count_r, count_nxt;
  logic      out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  val_t      value_r, value_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  cell_ctl_t ctl;
  logic      accept;
  logic      finish;
  logic      full;
  logic      hit;
  idx_t      g_idx;
  val_t      g_val;

  logic [CAPACITY-1:0] lt_w, eq_w, bnd_w, occ_w;
  key_t      keys [CAPACITY];
  val_t      vals [CAPACITY];

  // Handshake
  assign finish   = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_UPD) && finish));
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r >= CNT_W'(CAPACITY));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (finish) state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell commands
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_CMP: ctl.cmp_en = 1'b1;
      S_UPD: begin
        ctl.rep_en = finish && (func_r == FUNC_SET) && hit;
        ctl.ins_en = finish && (func_r == FUNC_SET) && !hit && !full;
      end
      default: ctl = '0;
    endcase
  end

  // Result and count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_NOT_FOUND;
    value_nxt  = '0;
    pos_nxt    = '0;
    if (func_r == FUNC_FIND) begin
      if (hit) begin
        status_nxt = ST_FOUND;
        value_nxt  = g_val;
        pos_nxt    = POS_W'(g_idx);
      end
    end else if (hit) begin
      status_nxt = ST_REPLACED;
      pos_nxt    = POS_W'(g_idx);
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_INSERTED;
      pos_nxt    = POS_W'(g_idx);
      count_nxt  = count_r + CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_UPD) && finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request, load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      req_key_r <= in_key_code;
      req_val_r <= in_entry_value;
    end
    if ((state_r == S_UPD) && finish) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // Row of cells, each fed by its lower neighbour, the first by the request
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_lt;
    key_t left_key;
    val_t left_val;

    assign occ_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = req_key_r;
      assign left_val = req_val_r;
    end else begin : g_rest
      assign left_lt  = lt_w[i-1];
      assign left_key = keys[i-1];
      assign left_val = vals[i-1];
    end

    skvt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_key  (req_key_r),
      .req_val  (req_val_r),
      .occ      (occ_w[i]),
      .left_lt  (left_lt),
      .left_key (left_key),
      .left_val (left_val),
      .key_r    (keys[i]),
      .val_r    (vals[i]),
      .lt_r     (lt_w[i]),
      .eq_r     (eq_w[i]),
      .bnd      (bnd_w[i])
    );
  end

  skvt_gather u_gather (
    .bnd  (bnd_w),
    .eq   (eq_w),
    .vals (vals),
    .idx  (g_idx),
    .val  (g_val),
    .hit  (hit)
  );

  // Drive the result port
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = value_r;
  assign out_position    = pos_r;
  assign out_entry_count = COUNT_W'(count_r);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_bnd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(bnd_w))
    else $error("more than one insertion boundary");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result loaded outside the update step");
`endif

endmodule
